@@ src/bisection_root_finder_cubic_top_macros.svh @@
// Assertion helpers shared by the RTL. Each expects clk and rst_n in scope.
`ifndef BISECTION_ROOT_FINDER_CUBIC_TOP_MACROS_SVH
`define BISECTION_ROOT_FINDER_CUBIC_TOP_MACROS_SVH

// Same-cycle implication.
`define BRFC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define BRFC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/brfc_pkg.sv @@
package brfc_pkg;

    localparam int FRAC_BITS_DEF = 24;

    localparam int DATA_W = 32;
    localparam int ERR_W  = 31;
    localparam int ITER_W = 8;

    localparam logic [ERR_W-1:0]  ERR_MAX      = '1;
    localparam logic [ERR_W-1:0]  TOL_RESET    = ERR_W'(1678);
    localparam logic [ITER_W-1:0] MAX_IT_RESET = ITER_W'(32);

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER  = 1'b1;

    // one quotient bit per divider step
    localparam int DIV_STEPS = ERR_W;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_SQ,
        OP_PLO,
        OP_PHI,
        OP_ACC,
        OP_SIGN_LO,
        OP_UPDATE,
        OP_MID,
        OP_DIFF,
        OP_ERR_INIT,
        OP_DIV
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic sat;
        logic stop;
    } dp_status_t;

endpackage

@@ src/brfc_ctrl.sv @@
module brfc_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    output logic               m_tvalid,
    input  logic               m_tready,
    output brfc_pkg::dp_cmd_t  cmd,
    input  brfc_pkg::dp_status_t status
);
    import brfc_pkg::*;

    localparam int CNT_W = $clog2(DIV_STEPS);

    typedef enum logic [3:0] {
        S_IDLE,
        S_SQ,
        S_PLO,
        S_PHI,
        S_ACC,
        S_SIGN,
        S_MID,
        S_DIFF,
        S_ERR,
        S_DIV,
        S_CHECK
    } state_t;

    state_t           state_reg, state_next;
    logic             first_reg, first_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             m_valid_reg, m_valid_next;

    always_comb
    begin
        state_next   = state_reg;
        first_next   = first_reg;
        cnt_next     = cnt_reg;
        cmd.op       = OP_NONE;
        cmd.out_load = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.op     = OP_LOAD;
                    first_next = 1'b1;
                    state_next = S_SQ;
                end
            end
            S_SQ:
            begin
                cmd.op     = OP_SQ;
                state_next = S_PLO;
            end
            S_PLO:
            begin
                cmd.op     = OP_PLO;
                state_next = S_PHI;
            end
            S_PHI:
            begin
                cmd.op     = OP_PHI;
                state_next = S_ACC;
            end
            S_ACC:
            begin
                cmd.op     = OP_ACC;
                state_next = S_SIGN;
            end
            S_SIGN:
            begin
                // first pass evaluates f at the lower end only
                cmd.op     = first_reg ? OP_SIGN_LO : OP_UPDATE;
                first_next = 1'b0;
                state_next = first_reg ? S_MID : S_DIFF;
            end
            S_MID:
            begin
                cmd.op     = OP_MID;
                state_next = S_SQ;
            end
            S_DIFF:
            begin
                cmd.op     = OP_DIFF;
                state_next = S_ERR;
            end
            S_ERR:
            begin
                cmd.op     = OP_ERR_INIT;
                cnt_next   = '0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (status.sat)
                begin
                    state_next = S_CHECK;
                end
                else
                begin
                    cmd.op   = OP_DIV;
                    cnt_next = cnt_reg + 1'b1;
                    if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                    begin
                        state_next = S_CHECK;
                    end
                end
            end
            S_CHECK:
            begin
                if (!status.stop)
                begin
                    state_next = S_MID;
                end
                else if (!m_valid_reg || m_tready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cmd.out_load)
        begin
            m_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_next = 1'b0;
        end
        else
        begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            first_reg   <= 1'b0;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            first_reg   <= first_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;

endmodule

@@ src/brfc_datapath.sv @@
module brfc_datapath #(
    parameter int FRAC_BITS = brfc_pkg::FRAC_BITS_DEF
) (
    input  logic                                clk,
    input  brfc_pkg::dp_cmd_t                   cmd,
    input  logic signed [brfc_pkg::DATA_W-1:0]  lower_bound,
    input  logic signed [brfc_pkg::DATA_W-1:0]  upper_bound,
    input  logic        [brfc_pkg::ERR_W-1:0]   tolerance,
    input  logic        [brfc_pkg::ITER_W-1:0]  max_iterations,
    output brfc_pkg::dp_status_t                status,
    output logic signed [brfc_pkg::DATA_W-1:0]  root,
    output logic        [brfc_pkg::ERR_W-1:0]   final_error,
    output logic        [brfc_pkg::ITER_W-1:0]  iteration_count,
    output logic                                limit_reached
);
    import brfc_pkg::*;

    localparam int A_W    = DATA_W + 2;         // x + 3.0, signed
    localparam int MB_W   = DATA_W + 1;         // positive part of a
    localparam int PR_W   = DATA_W + MB_W;      // one partial product
    localparam int SQ_W   = 2 * DATA_W;
    localparam int P_W    = 3 * DATA_W;         // full cubic product
    localparam int D_W    = DATA_W + 1;         // |upper - lower|
    localparam int NUM_W  = D_W + FRAC_BITS;    // scaled numerator
    localparam int CMP_W  = 2 * DATA_W;

    localparam logic [A_W-1:0] THREE_ONE = A_W'(3) << FRAC_BITS;
    localparam logic [P_W-1:0] CUBE_ONE  = P_W'(1) << (3 * FRAC_BITS);

    logic signed [DATA_W-1:0] lo_reg, lo_next;
    logic signed [DATA_W-1:0] up_reg, up_next;
    logic signed [DATA_W-1:0] x_reg, x_next;
    logic [ITER_W-1:0]        iter_reg, iter_next;
    logic [SQ_W-1:0]          sq_reg, sq_next;
    logic [PR_W-1:0]          prod_reg, prod_next;
    logic [P_W-1:0]           p_reg, p_next;
    logic                     sl_pos_reg, sl_pos_next;
    logic                     sl_neg_reg, sl_neg_next;
    logic [D_W-1:0]           diff_reg, diff_next;
    logic [DATA_W-1:0]        den_reg, den_next;
    logic                     sat_reg, sat_next;
    logic [ERR_W-1:0]         err_reg, err_next;
    logic [DATA_W-1:0]        rem_reg, rem_next;
    logic [ERR_W-1:0]         numlo_reg, numlo_next;

    logic signed [DATA_W-1:0] out_root_reg;
    logic [ERR_W-1:0]         out_err_reg;
    logic [ITER_W-1:0]        out_iter_reg;
    logic                     out_limit_reg;

    logic [DATA_W-1:0] mag;
    logic [A_W-1:0]    a_val;
    logic              a_pos;
    logic              sx_pos, sx_neg;
    logic [DATA_W-1:0] mul_a;
    logic [MB_W-1:0]   mul_b;
    logic [PR_W-1:0]   prod;
    logic [D_W-1:0]    sum;
    logic [D_W-1:0]    dsub;
    logic [NUM_W-1:0]  num;
    logic              sat;
    logic [D_W-1:0]    shifted;
    logic [D_W:0]      trial;
    logic              limit;

    // cubic operand and its sign from the accumulated product
    assign mag    = x_reg[DATA_W-1] ? DATA_W'(-x_reg) : DATA_W'(x_reg);
    assign a_val  = {{2{x_reg[DATA_W-1]}}, x_reg} + THREE_ONE;
    assign a_pos  = !a_val[A_W-1] && (a_val != '0);
    assign sx_pos = a_pos && (p_reg > CUBE_ONE);
    assign sx_neg = !a_pos || (p_reg < CUBE_ONE);

    // shared 32x33 multiplier
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            OP_SQ:
            begin
                mul_a = mag;
                mul_b = {1'b0, mag};
            end
            OP_PLO:
            begin
                mul_a = sq_reg[DATA_W-1:0];
                mul_b = a_val[MB_W-1:0];
            end
            OP_PHI:
            begin
                mul_a = sq_reg[SQ_W-1:DATA_W];
                mul_b = a_val[MB_W-1:0];
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod = PR_W'(mul_a) * PR_W'(mul_b);

    assign sum  = {lo_reg[DATA_W-1], lo_reg} + {up_reg[DATA_W-1], up_reg};
    assign dsub = {up_reg[DATA_W-1], up_reg} - {lo_reg[DATA_W-1], lo_reg};
    assign num  = NUM_W'(diff_reg) << FRAC_BITS;
    // quotient would not fit in ERR_W bits
    assign sat  = (den_reg == '0) ||
                  (CMP_W'(num) >= {1'b0, den_reg, {ERR_W{1'b0}}});

    assign shifted = {rem_reg, numlo_reg[ERR_W-1]};
    assign trial   = {1'b0, shifted} - {2'b00, den_reg};

    assign limit = (iter_reg >= max_iterations);

    always_comb
    begin
        lo_next     = lo_reg;
        up_next     = up_reg;
        x_next      = x_reg;
        iter_next   = iter_reg;
        sq_next     = sq_reg;
        prod_next   = prod_reg;
        p_next      = p_reg;
        sl_pos_next = sl_pos_reg;
        sl_neg_next = sl_neg_reg;
        diff_next   = diff_reg;
        den_next    = den_reg;
        sat_next    = sat_reg;
        err_next    = err_reg;
        rem_next    = rem_reg;
        numlo_next  = numlo_reg;
        case (cmd.op)
            OP_LOAD:
            begin
                lo_next   = lower_bound;
                up_next   = upper_bound;
                x_next    = lower_bound;
                iter_next = '0;
            end
            OP_SQ:
            begin
                sq_next = prod[SQ_W-1:0];
            end
            OP_PLO:
            begin
                prod_next = prod;
            end
            OP_PHI:
            begin
                p_next    = P_W'(prod_reg);
                prod_next = prod;
            end
            OP_ACC:
            begin
                p_next = p_reg + (P_W'(prod_reg) << DATA_W);
            end
            OP_SIGN_LO:
            begin
                sl_pos_next = sx_pos;
                sl_neg_next = sx_neg;
            end
            OP_UPDATE:
            begin
                // strict sign change between lower end and midpoint
                if ((sx_pos && sl_neg_reg) || (sx_neg && sl_pos_reg))
                begin
                    up_next = x_reg;
                end
                else
                begin
                    lo_next     = x_reg;
                    sl_pos_next = sx_pos;
                    sl_neg_next = sx_neg;
                end
            end
            OP_MID:
            begin
                x_next    = sum[D_W-1:1];
                iter_next = iter_reg + 1'b1;
            end
            OP_DIFF:
            begin
                diff_next = dsub[D_W-1] ? D_W'(-dsub) : dsub;
                den_next  = up_reg[DATA_W-1] ? DATA_W'(-up_reg) : DATA_W'(up_reg);
            end
            OP_ERR_INIT:
            begin
                sat_next   = sat;
                err_next   = sat ? ERR_MAX : '0;
                rem_next   = DATA_W'(num >> ERR_W);
                numlo_next = num[ERR_W-1:0];
            end
            OP_DIV:
            begin
                if (!trial[D_W])
                begin
                    rem_next = trial[DATA_W-1:0];
                end
                else
                begin
                    rem_next = shifted[DATA_W-1:0];
                end
                err_next   = {err_reg[ERR_W-2:0], !trial[D_W]};
                numlo_next = numlo_reg << 1;
            end
            default:
            begin
                lo_next = lo_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        lo_reg     <= lo_next;
        up_reg     <= up_next;
        x_reg      <= x_next;
        iter_reg   <= iter_next;
        sq_reg     <= sq_next;
        prod_reg   <= prod_next;
        p_reg      <= p_next;
        sl_pos_reg <= sl_pos_next;
        sl_neg_reg <= sl_neg_next;
        diff_reg   <= diff_next;
        den_reg    <= den_next;
        sat_reg    <= sat_next;
        err_reg    <= err_next;
        rem_reg    <= rem_next;
        numlo_reg  <= numlo_next;
        if (cmd.out_load)
        begin
            out_root_reg  <= x_reg;
            out_err_reg   <= err_reg;
            out_iter_reg  <= iter_reg;
            out_limit_reg <= limit;
        end
    end

    assign status.sat  = sat_reg;
    assign status.stop = (err_reg <= tolerance) || limit;

    assign root            = out_root_reg;
    assign final_error     = out_err_reg;
    assign iteration_count = out_iter_reg;
    assign limit_reached   = out_limit_reg;

endmodule

@@ src/bisection_root_finder_cubic_top.sv @@
// Bisection root finder for f(x) = x^3 + 3x^2 - 1 on signed Q8.24 numbers.
// Each input transfer carries a bracket (lower_bound, upper_bound); the block
// bisects it, testing the exact sign of f at each midpoint, keeps the half
// with a strict sign change (otherwise the upper half), and stops when the
// relative error |(upper-lower)/upper| is not above tolerance or the
// iteration count reaches max_iterations. Exactly one output transfer
// follows each input: the last midpoint, the error (saturated to 2^31-1,
// also when upper is zero), the iteration count, and limit_reached in tuser,
// set whenever the count reached the limit (root not trusted). A limit of 0
// runs one iteration. No bracket check is made. One item is taken at a time.
// Each iteration forms the cubic in three products per midpoint on the single
// 32x33 multiplier and then runs the 31-step restoring divider; an iteration
// whose error saturates skips the divider. The next bracket is taken while a
// finished result waits in the output register. Configuration writes
// (cfg_index 0 = tolerance, 1 = max_iterations) belong to idle time only.
`include "bisection_root_finder_cubic_top_macros.svh"

module bisection_root_finder_cubic_top #(
    parameter int FRAC_BITS = brfc_pkg::FRAC_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // input stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [2*brfc_pkg::DATA_W-1:0]     s_tdata,   // lower_bound, upper_bound
    // result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [71:0]                       m_tdata,   // root, final_error,
                                                         // iteration_count, pad
    output logic                              m_tuser,   // limit_reached
    // configuration writes
    input  logic                              cfg_we,
    input  logic [brfc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [brfc_pkg::ERR_W-1:0]        cfg_wdata
);
    import brfc_pkg::*;

    localparam int OUT_BITS = DATA_W + ERR_W + ITER_W;

    logic [ERR_W-1:0]  tol_reg;
    logic [ITER_W-1:0] max_it_reg;

    dp_cmd_t    cmd;
    dp_status_t status;

    logic signed [DATA_W-1:0] root;
    logic [ERR_W-1:0]         final_error;
    logic [ITER_W-1:0]        iteration_count;
    logic                     limit_reached;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg    <= TOL_RESET;
            max_it_reg <= MAX_IT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_TOLERANCE: tol_reg    <= cfg_wdata;
                REG_MAX_ITER:  max_it_reg <= cfg_wdata[ITER_W-1:0];
                default:       tol_reg    <= tol_reg;
            endcase
        end
    end

    brfc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .status   (status)
    );

    brfc_datapath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath (
        .clk             (clk),
        .cmd             (cmd),
        .lower_bound     (s_tdata[DATA_W-1:0]),
        .upper_bound     (s_tdata[2*DATA_W-1:DATA_W]),
        .tolerance       (tol_reg),
        .max_iterations  (max_it_reg),
        .status          (status),
        .root            (root),
        .final_error     (final_error),
        .iteration_count (iteration_count),
        .limit_reached   (limit_reached)
    );

    assign m_tdata = {{(72 - OUT_BITS){1'b0}}, iteration_count, final_error, root};
    assign m_tuser = limit_reached;

    // one bracket in flight: no second transfer right after one
    `BRFC_ASSERT_NEXT(a_one_in_flight, s_tvalid && s_tready, !s_tready, "second bracket taken while busy")
    // every result has run at least one iteration
    `BRFC_ASSERT_NOW(a_count_nonzero, m_tvalid, iteration_count != '0, "result with zero iterations")
    // a result appears only at the end of work, never straight from idle
    `BRFC_ASSERT_NOW(a_result_after_work, $rose(m_tvalid), $past(!s_tready), "result without work")

endmodule
